/* sv/bounded_array_list_macros.svh */
// Assertion macros shared by the checker of the bounded array list.
`ifndef BOUNDED_ARRAY_LIST_MACROS_SVH
`define BOUNDED_ARRAY_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/bal_pkg.sv */
package bal_pkg;

	localparam int CAPACITY = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int CNT_W = 7;
	localparam int WORD_W = 32;

	localparam logic [WORD_W-1:0] FAIL_WORD = WORD_W'(-99999);

	typedef enum logic [2:0] {
		OP_READ,
		OP_APPEND,
		OP_INSERT,
		OP_REMOVE_AT,
		OP_REMOVE_VAL
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_RANGE,
		ST_MISSING,
		ST_FULL
	} status_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_POS,
		IDX_CNT,
		IDX_INC,
		IDX_DEC
	} idx_sel_t;

	typedef enum logic [1:0] {
		RA_POS,
		RA_IDX,
		RA_IDX_DN,
		RA_IDX_UP
	} raddr_sel_t;

	typedef enum logic {
		WA_CNT,
		WA_IDX
	} waddr_sel_t;

	typedef enum logic {
		WD_VAL,
		WD_RDATA
	} wdata_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FAIL,
		RES_RDATA
	} res_sel_t;

	typedef struct packed {
		logic       latch;
		idx_sel_t   idx_sel;
		raddr_sel_t ra_sel;
		logic       wr;
		waddr_sel_t wa_sel;
		wdata_sel_t wd_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_load;
		res_sel_t   res_sel;
		status_t    res_status;
		logic       publish;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic pos_lt_cnt;
		logic pos_gt_cnt;
		logic idx_eq_pos;
		logic idx_last;
		logic idx_lt_cnt;
		logic match;
	} stat_t;

endpackage

/* sv/bal_ctrl.sv */
module bal_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  bal_pkg::stat_t stat,
	output bal_pkg::cmd_t  cmd
);
	import bal_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_WAIT,
		S_INS_CHK,
		S_INS_WR,
		S_RM_CAP,
		S_SH_CHK,
		S_SH_WR,
		S_SC_CHK,
		S_SC_CMP,
		S_FINISH
	} state_t;

	state_t state_q, state_nx;
	logic   out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd = '{latch: 1'b0, idx_sel: IDX_HOLD, ra_sel: RA_IDX, wr: 1'b0, wa_sel: WA_IDX,
			wd_sel: WD_RDATA, cnt_inc: 1'b0, cnt_dec: 1'b0, res_load: 1'b0,
			res_sel: RES_ZERO, res_status: ST_OK, publish: 1'b0};
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					OP_READ: begin
						if (stat.pos_lt_cnt) begin
							cmd.ra_sel = RA_POS;
							state_nx = S_RD_WAIT;
						end else begin
							cmd.res_load = 1'b1;
							cmd.res_sel = RES_FAIL;
							cmd.res_status = ST_RANGE;
							state_nx = S_FINISH;
						end
					end
					OP_APPEND: begin
						cmd.res_load = 1'b1;
						if (stat.full) begin
							cmd.res_sel = RES_FAIL;
							cmd.res_status = ST_FULL;
						end else begin
							cmd.wr = 1'b1;
							cmd.wa_sel = WA_CNT;
							cmd.wd_sel = WD_VAL;
							cmd.cnt_inc = 1'b1;
						end
						state_nx = S_FINISH;
					end
					OP_INSERT: begin
						if (stat.full) begin
							cmd.res_load = 1'b1;
							cmd.res_sel = RES_FAIL;
							cmd.res_status = ST_FULL;
							state_nx = S_FINISH;
						end else if (stat.pos_gt_cnt) begin
							cmd.res_load = 1'b1;
							cmd.res_sel = RES_FAIL;
							cmd.res_status = ST_RANGE;
							state_nx = S_FINISH;
						end else begin
							cmd.idx_sel = IDX_CNT;
							state_nx = S_INS_CHK;
						end
					end
					OP_REMOVE_AT: begin
						if (stat.pos_lt_cnt) begin
							cmd.idx_sel = IDX_POS;
							cmd.ra_sel = RA_POS;
							state_nx = S_RM_CAP;
						end else begin
							cmd.res_load = 1'b1;
							cmd.res_sel = RES_FAIL;
							cmd.res_status = ST_RANGE;
							state_nx = S_FINISH;
						end
					end
					OP_REMOVE_VAL: begin
						cmd.idx_sel = IDX_ZERO;
						state_nx = S_SC_CHK;
					end
					default: begin
						cmd.res_load = 1'b1;
						state_nx = S_FINISH;
					end
				endcase
			end
			S_RD_WAIT: begin
				cmd.res_load = 1'b1;
				cmd.res_sel = RES_RDATA;
				state_nx = S_FINISH;
			end
			S_INS_CHK: begin
				if (stat.idx_eq_pos) begin
					cmd.wr = 1'b1;
					cmd.wd_sel = WD_VAL;
					cmd.cnt_inc = 1'b1;
					cmd.res_load = 1'b1;
					state_nx = S_FINISH;
				end else begin
					cmd.ra_sel = RA_IDX_DN;
					state_nx = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.wr = 1'b1;
				cmd.idx_sel = IDX_DEC;
				state_nx = S_INS_CHK;
			end
			S_RM_CAP: begin
				cmd.res_load = 1'b1;
				cmd.res_sel = RES_RDATA;
				state_nx = S_SH_CHK;
			end
			S_SH_CHK: begin
				if (stat.idx_last) begin
					cmd.cnt_dec = 1'b1;
					state_nx = S_FINISH;
				end else begin
					cmd.ra_sel = RA_IDX_UP;
					state_nx = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.wr = 1'b1;
				cmd.idx_sel = IDX_INC;
				state_nx = S_SH_CHK;
			end
			S_SC_CHK: begin
				if (stat.idx_lt_cnt) begin
					state_nx = S_SC_CMP;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_sel = RES_FAIL;
					cmd.res_status = ST_MISSING;
					state_nx = S_FINISH;
				end
			end
			S_SC_CMP: begin
				if (stat.match) begin
					cmd.res_load = 1'b1;
					cmd.res_sel = RES_RDATA;
					state_nx = S_SH_CHK;
				end else begin
					cmd.idx_sel = IDX_INC;
					state_nx = S_SC_CHK;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.publish) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

/* sv/bal_dpath.sv */
module bal_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bal_pkg::cmd_t                       cmd,
	output bal_pkg::stat_t                      stat,
	input  logic [2:0]                          opcode,
	input  logic [bal_pkg::CNT_W-1:0]           position,
	input  logic signed [bal_pkg::WORD_W-1:0]   value,
	output logic signed [bal_pkg::WORD_W-1:0]   data,
	output logic [1:0]                          status,
	output logic [bal_pkg::CNT_W-1:0]           entry_count
);
	import bal_pkg::*;

	logic [WORD_W-1:0] mem_q [CAPACITY];
	logic [WORD_W-1:0] rdata_q;

	logic [2:0]        op_q;
	logic [CNT_W-1:0]  pos_q;
	logic [WORD_W-1:0] val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [WORD_W-1:0] res_data_q;
	status_t           res_status_q;
	logic [WORD_W-1:0] data_q;
	status_t           status_q;
	logic [CNT_W-1:0]  count_q;

	logic [CNT_W-1:0]  idx_dn;
	logic [CNT_W-1:0]  idx_up;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] res_word;

	assign idx_dn = idx_q - CNT_W'(1);
	assign idx_up = idx_q + CNT_W'(1);

	always_comb begin
		case (cmd.ra_sel)
			RA_POS:    raddr = pos_q[AW-1:0];
			RA_IDX:    raddr = idx_q[AW-1:0];
			RA_IDX_DN: raddr = idx_dn[AW-1:0];
			RA_IDX_UP: raddr = idx_up[AW-1:0];
			default:   raddr = idx_q[AW-1:0];
		endcase
	end

	assign waddr = (cmd.wa_sel == WA_CNT) ? cnt_q[AW-1:0] : idx_q[AW-1:0];
	assign wdata = (cmd.wd_sel == WD_VAL) ? val_q : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_comb begin
		case (cmd.res_sel)
			RES_ZERO:  res_word = '0;
			RES_FAIL:  res_word = FAIL_WORD;
			RES_RDATA: res_word = rdata_q;
			default:   res_word = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= opcode;
			pos_q <= position;
			val_q <= value;
		end
		if (cmd.res_load) begin
			res_data_q <= res_word;
			res_status_q <= cmd.res_status;
		end
		if (cmd.publish) begin
			data_q <= res_data_q;
			status_q <= res_status_q;
			count_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			case (cmd.idx_sel)
				IDX_HOLD: idx_q <= idx_q;
				IDX_ZERO: idx_q <= '0;
				IDX_POS:  idx_q <= pos_q;
				IDX_CNT:  idx_q <= cnt_q;
				IDX_INC:  idx_q <= idx_up;
				IDX_DEC:  idx_q <= idx_dn;
				default:  idx_q <= idx_q;
			endcase
		end
	end

	assign stat.op = op_t'(op_q);
	assign stat.full = (cnt_q >= CNT_W'(CAPACITY));
	assign stat.pos_lt_cnt = (pos_q < cnt_q);
	assign stat.pos_gt_cnt = (pos_q > cnt_q);
	assign stat.idx_eq_pos = (idx_q == pos_q);
	assign stat.idx_last = (idx_up >= cnt_q);
	assign stat.idx_lt_cnt = (idx_q < cnt_q);
	assign stat.match = (rdata_q == val_q);

	assign data = data_q;
	assign status = status_q;
	assign entry_count = count_q;

endmodule

/* sv/bounded_array_list.sv */
// Channel   Handshake             Words carried
// input     in_valid / in_stall   opcode, position, value
// output    out_valid / out_stall data, status, entry_count
//
// A read returns its entry through the registered memory read; an append, an undefined
// opcode or a refusal at decode finishes there. An insert at p moves entry p and those
// above it up one place, a remove at p returns entry p and moves later ones down, and a
// remove by value scans from entry 0 and removes the first match; each shift reads, then
// writes. Reset clears the count and the controller; entries stay as they are. A result
// held by out_stall delays the next result, not the next input.
module bounded_array_list (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         opcode,
	input  logic [bal_pkg::CNT_W-1:0]          position,
	input  logic signed [bal_pkg::WORD_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [bal_pkg::WORD_W-1:0]  data,
	output logic [1:0]                         status,
	output logic [bal_pkg::CNT_W-1:0]          entry_count
);
	import bal_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	bal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bal_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.position    (position),
		.value       (value),
		.data        (data),
		.status      (status),
		.entry_count (entry_count)
	);

endmodule

/* sv/bal_checker.sv */
`include "bounded_array_list_macros.svh"

module bal_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [2:0]                         opcode,
	input logic [bal_pkg::CNT_W-1:0]          position,
	input logic signed [bal_pkg::WORD_W-1:0]  value,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [bal_pkg::WORD_W-1:0]  data,
	input logic [1:0]                         status,
	input logic [bal_pkg::CNT_W-1:0]          entry_count
);
	import bal_pkg::*;

	`BAL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data) && $stable(status) && $stable(entry_count), "stalled result word changed")
	`BAL_ASSERT_NOW(a_fail_word, out_valid && (status != ST_OK), data == FAIL_WORD, "failure status without the failure word")
	`BAL_ASSERT_NOW(a_count_bound, out_valid, entry_count <= CNT_W'(CAPACITY), "entry count beyond capacity")
	`BAL_ASSERT_NOW(a_full_count, out_valid && (status == ST_FULL), entry_count == CNT_W'(CAPACITY), "full status while the list is not full")
	`BAL_ASSERT_NEXT(a_busy_after, in_valid && !in_stall, in_stall, "block ready again straight after taking a word")

endmodule

bind bounded_array_list bal_checker u_bal_checker (.*);
